@@ src/relative_strength_index_macros.svh @@
// ---------------------------------------------------------------------------
// relative strength index assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef RELATIVE_STRENGTH_INDEX_MACROS_SVH
`define RELATIVE_STRENGTH_INDEX_MACROS_SVH

// condition implies consequence in the same cycle
`define RSI_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/rsi_pkg.sv @@
// ---------------------------------------------------------------------------
// rsi_pkg
// constants, control word types and the microprogram of the rsi sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

   // fixed widths and constants
   localparam int               PERIOD_BITS  = 8;
   localparam int               RATIO_BITS   = 15;
   localparam logic [7:0]       PERIOD_RESET = 8'd14;
   localparam logic [14:0]      RSI_FULL     = 15'd25600;

   // datapath operation of one step
   typedef enum logic [3:0] {
      OP_EMIT,
      OP_WAIT,
      OP_DELTA,
      OP_NOP,
      OP_MUL,
      OP_ACCUM,
      OP_LOADSUM,
      OP_DIVN,
      OP_STORE,
      OP_RATIO,
      OP_DIVR,
      OP_DONE
   } op_type;

   // jump condition of one step
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ACCEPT,
      COND_START,
      COND_WARM,
      COND_MORE_WARM,
      COND_ITER,
      COND_LOSS_ZERO,
      COND_BUSY
   } cond_type;

   typedef logic [3:0] step_addr_type;

   // program addresses
   localparam step_addr_type STEP_EMIT    = 4'd0;
   localparam step_addr_type STEP_WAIT    = 4'd1;
   localparam step_addr_type STEP_DELTA   = 4'd2;
   localparam step_addr_type STEP_CHECK   = 4'd3;
   localparam step_addr_type STEP_MUL     = 4'd4;
   localparam step_addr_type STEP_ACCUM   = 4'd5;
   localparam step_addr_type STEP_LOADSUM = 4'd6;
   localparam step_addr_type STEP_DIVN    = 4'd7;
   localparam step_addr_type STEP_STORE   = 4'd8;
   localparam step_addr_type STEP_RATIO   = 4'd9;
   localparam step_addr_type STEP_DIVR    = 4'd10;
   localparam step_addr_type STEP_DONE    = 4'd11;

   typedef struct packed {
      op_type        op;
      cond_type      cond;
      step_addr_type target;
   } ctrl_word_type;

   // microprogram rom: a taken condition jumps to target, else falls through
   function automatic ctrl_word_type ucode(input step_addr_type addr);
      ctrl_word_type w;
      case (addr)
         STEP_EMIT:    w = '{OP_EMIT,    COND_BUSY,      STEP_EMIT};
         STEP_WAIT:    w = '{OP_WAIT,    COND_NO_ACCEPT, STEP_WAIT};
         STEP_DELTA:   w = '{OP_DELTA,   COND_START,     STEP_WAIT};
         STEP_CHECK:   w = '{OP_NOP,     COND_WARM,      STEP_ACCUM};
         STEP_MUL:     w = '{OP_MUL,     COND_ALWAYS,    STEP_DIVN};
         STEP_ACCUM:   w = '{OP_ACCUM,   COND_MORE_WARM, STEP_WAIT};
         STEP_LOADSUM: w = '{OP_LOADSUM, COND_NEVER,     STEP_DIVN};
         STEP_DIVN:    w = '{OP_DIVN,    COND_ITER,      STEP_DIVN};
         STEP_STORE:   w = '{OP_STORE,   COND_NEVER,     STEP_RATIO};
         STEP_RATIO:   w = '{OP_RATIO,   COND_LOSS_ZERO, STEP_EMIT};
         STEP_DIVR:    w = '{OP_DIVR,    COND_ITER,      STEP_DIVR};
         STEP_DONE:    w = '{OP_DONE,    COND_ALWAYS,    STEP_EMIT};
         default:      w = '{OP_NOP,     COND_ALWAYS,    STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ src/rsi_if.sv @@
// ---------------------------------------------------------------------------
// rsi channel interfaces
// valid/ready channels for price beats in and rsi beats out
// ---------------------------------------------------------------------------
`default_nettype none

// price channel
interface rsi_req_if #(parameter int PRICE_BITS = 32) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  series_start;

   modport source (output valid, price, series_start, input ready);
   modport sink   (input valid, price, series_start, output ready);
endinterface

// rsi result channel
interface rsi_rsp_if ();
   import rsi_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [RATIO_BITS-1:0] rsi_value;

   modport source (output valid, rsi_value, input ready);
   modport sink   (input valid, rsi_value, output ready);
endinterface

`default_nettype wire

@@ src/relative_strength_index.sv @@
// ---------------------------------------------------------------------------
// relative_strength_index
// wilder rsi over a stream of fixed point prices, run by a microcoded
// sequencer around two lanes of a restoring divider
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   req      in   valid/ready         price, series_start
//   rsp      out  valid/ready         rsi_value
//   csr      in   write enable only   period
//
// one beat at a time; ready is high only while the sequencer waits at the
// wait step. a smoothed beat runs the divider lanes over the averages and
// then the gain lane over the ratio; the beat that closes the warm-up first
// sums, then divides; a beat with zero average loss skips the ratio division,
// and a warm-up beat or a series start does not divide at all.
// reset is synchronous and clears the sequencer, the state and the period
// (to 14). a held result sits in the output register while the next beat
// is taken; the sequencer stalls at the emit step only if it is still full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "relative_strength_index_macros.svh"

module relative_strength_index #(
   parameter int PRICE_BITS          = 32,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rsi_req_if.sink                             req,
   rsi_rsp_if.source                           rsp,
   input  wire logic                           csr_write_enable,
   input  wire logic [rsi_pkg::PERIOD_BITS-1:0] csr_write_data
);

   import rsi_pkg::*;

   localparam int CHANGE_BITS = PRICE_BITS + EXTRA_FRACTION_BITS;
   localparam int AVG_BITS    = CHANGE_BITS + PERIOD_BITS;
   localparam int PROD_BITS   = AVG_BITS + PERIOD_BITS;
   localparam int NUM_BITS    = AVG_BITS + RATIO_BITS;
   localparam int ITER_BITS   = $clog2(AVG_BITS + 1);
   localparam logic [ITER_BITS-1:0] ITER_AVG   = ITER_BITS'(AVG_BITS);
   localparam logic [ITER_BITS-1:0] ITER_RATIO = ITER_BITS'(RATIO_BITS);

   // sequencer
   step_addr_type              pc_ff, pc_in;
   logic [ITER_BITS-1:0]       iter_ff, iter_in;
   ctrl_word_type              cw;

   // configuration and state
   logic [PERIOD_BITS-1:0]     period_ff, period_in;
   logic [PRICE_BITS-1:0]      price_ff, price_in;
   logic                       start_ff, start_in;
   logic [PRICE_BITS-1:0]      last_price_ff, last_price_in;
   logic [PERIOD_BITS-1:0]     count_ff, count_in;
   logic [AVG_BITS-1:0]        gain_avg_ff, gain_avg_in;
   logic [AVG_BITS-1:0]        loss_avg_ff, loss_avg_in;
   logic [CHANGE_BITS-1:0]     gain_x_ff, gain_x_in;
   logic [CHANGE_BITS-1:0]     loss_x_ff, loss_x_in;

   // divider lanes
   logic [AVG_BITS:0]          rem_g_ff, rem_g_in;
   logic [AVG_BITS-1:0]        qs_g_ff, qs_g_in;
   logic [PERIOD_BITS-1:0]     rem_l_ff, rem_l_in;
   logic [AVG_BITS-1:0]        qs_l_ff, qs_l_in;
   logic [AVG_BITS:0]          sum_ff, sum_in;

   // result
   logic [RATIO_BITS-1:0]      rsi_res_ff, rsi_res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RATIO_BITS-1:0]      rsp_value_ff, rsp_value_in;

   // helpers
   logic                       accept_w;
   logic                       rsp_busy_w;
   logic                       take_w;
   logic [PERIOD_BITS-1:0]     n_w;
   logic [PERIOD_BITS-1:0]     nm1_w;
   logic [PERIOD_BITS-1:0]     count_inc_w;
   logic                       warm_w;
   logic                       more_warm_w;
   logic                       rising_w;
   logic [PRICE_BITS-1:0]      diff_up_w;
   logic [PRICE_BITS-1:0]      diff_dn_w;
   logic [PROD_BITS-1:0]       gain_num_w;
   logic [PROD_BITS-1:0]       loss_num_w;
   logic [NUM_BITS-1:0]        ratio_num_w;
   logic [AVG_BITS:0]          divisor_w;
   logic [AVG_BITS+2:0]        trial_g_w;
   logic                       qbit_g_w;
   logic [AVG_BITS:0]          rem_g_step_w;
   logic [PERIOD_BITS+1:0]     trial_l_w;
   logic                       qbit_l_w;
   logic [PERIOD_BITS-1:0]     rem_l_step_w;

   assign cw = ucode(pc_ff);

   // handshake
   assign accept_w      = req.valid & req.ready;
   assign req.ready     = (pc_ff == STEP_WAIT);
   assign rsp_busy_w    = rsp_valid_ff & ~rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.rsi_value = rsp_value_ff;

   // period and warm-up tests, period zero acts as one
   assign n_w         = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
   assign nm1_w       = n_w - PERIOD_BITS'(1);
   assign count_inc_w = count_ff + PERIOD_BITS'(1);
   assign warm_w      = (count_ff < n_w);
   assign more_warm_w = (count_inc_w < n_w);

   // price change split
   assign rising_w  = (price_ff > last_price_ff);
   assign diff_up_w = price_ff - last_price_ff;
   assign diff_dn_w = last_price_ff - price_ff;

   // wilder numerators avg*(n-1)+x
   assign gain_num_w = PROD_BITS'(gain_avg_ff) * PROD_BITS'(nm1_w) + PROD_BITS'(gain_x_ff);
   assign loss_num_w = PROD_BITS'(loss_avg_ff) * PROD_BITS'(nm1_w) + PROD_BITS'(loss_x_ff);

   // ratio numerator 25600*g
   assign ratio_num_w = NUM_BITS'(gain_avg_ff) * NUM_BITS'(RSI_FULL);

   // gain lane restoring step, divisor is n or g+l
   assign divisor_w = (cw.op == OP_DIVR) ? sum_ff : (AVG_BITS + 1)'(n_w);
   assign trial_g_w = {1'b0, rem_g_ff, qs_g_ff[AVG_BITS-1]} - {2'b00, divisor_w};
   assign qbit_g_w  = ~trial_g_w[AVG_BITS+2];
   assign rem_g_step_w = qbit_g_w ? trial_g_w[AVG_BITS:0]
                                  : {rem_g_ff[AVG_BITS-1:0], qs_g_ff[AVG_BITS-1]};

   // loss lane restoring step, divisor is n
   assign trial_l_w = {1'b0, rem_l_ff, qs_l_ff[AVG_BITS-1]} - {2'b00, n_w};
   assign qbit_l_w  = ~trial_l_w[PERIOD_BITS+1];
   assign rem_l_step_w = qbit_l_w ? trial_l_w[PERIOD_BITS-1:0]
                                  : {rem_l_ff[PERIOD_BITS-2:0], qs_l_ff[AVG_BITS-1]};

   // next step
   always_comb begin
      case (cw.cond)
         COND_NEVER:     take_w = 1'b0;
         COND_ALWAYS:    take_w = 1'b1;
         COND_NO_ACCEPT: take_w = ~accept_w;
         COND_START:     take_w = start_ff;
         COND_WARM:      take_w = warm_w;
         COND_MORE_WARM: take_w = more_warm_w;
         COND_ITER:      take_w = (iter_ff != ITER_BITS'(1));
         COND_LOSS_ZERO: take_w = (loss_avg_ff == '0);
         COND_BUSY:      take_w = rsp_busy_w;
         default:        take_w = 1'b0;
      endcase
      pc_in = take_w ? cw.target : pc_ff + step_addr_type'(1);
   end

   // datapath control
   always_comb begin
      period_in     = csr_write_enable ? csr_write_data : period_ff;
      iter_in       = iter_ff;
      price_in      = price_ff;
      start_in      = start_ff;
      last_price_in = last_price_ff;
      count_in      = count_ff;
      gain_avg_in   = gain_avg_ff;
      loss_avg_in   = loss_avg_ff;
      gain_x_in     = gain_x_ff;
      loss_x_in     = loss_x_ff;
      rem_g_in      = rem_g_ff;
      qs_g_in       = qs_g_ff;
      rem_l_in      = rem_l_ff;
      qs_l_in       = qs_l_ff;
      sum_in        = sum_ff;
      rsi_res_in    = rsi_res_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_value_in  = rsp_value_ff;
      case (cw.op)
         OP_WAIT: begin
            if (accept_w) begin
               price_in = req.price;
               start_in = req.series_start;
            end
         end
         OP_DELTA: begin
            last_price_in = price_ff;
            if (start_ff) begin
               count_in    = '0;
               gain_avg_in = '0;
               loss_avg_in = '0;
            end else if (rising_w) begin
               gain_x_in = CHANGE_BITS'(diff_up_w) << EXTRA_FRACTION_BITS;
               loss_x_in = '0;
            end else begin
               gain_x_in = '0;
               loss_x_in = CHANGE_BITS'(diff_dn_w) << EXTRA_FRACTION_BITS;
            end
         end
         OP_MUL: begin
            rem_g_in = (AVG_BITS + 1)'(gain_num_w[PROD_BITS-1:AVG_BITS]);
            qs_g_in  = gain_num_w[AVG_BITS-1:0];
            rem_l_in = loss_num_w[PROD_BITS-1:AVG_BITS];
            qs_l_in  = loss_num_w[AVG_BITS-1:0];
            iter_in  = ITER_AVG;
         end
         OP_ACCUM: begin
            gain_avg_in = gain_avg_ff + AVG_BITS'(gain_x_ff);
            loss_avg_in = loss_avg_ff + AVG_BITS'(loss_x_ff);
            count_in    = count_inc_w;
         end
         OP_LOADSUM: begin
            rem_g_in = '0;
            qs_g_in  = gain_avg_ff;
            rem_l_in = '0;
            qs_l_in  = loss_avg_ff;
            iter_in  = ITER_AVG;
         end
         OP_DIVN: begin
            rem_g_in = rem_g_step_w;
            qs_g_in  = {qs_g_ff[AVG_BITS-2:0], qbit_g_w};
            rem_l_in = rem_l_step_w;
            qs_l_in  = {qs_l_ff[AVG_BITS-2:0], qbit_l_w};
            iter_in  = iter_ff - ITER_BITS'(1);
         end
         OP_STORE: begin
            gain_avg_in = qs_g_ff;
            loss_avg_in = qs_l_ff;
         end
         OP_RATIO: begin
            sum_in     = (AVG_BITS + 1)'(gain_avg_ff) + (AVG_BITS + 1)'(loss_avg_ff);
            rem_g_in   = (AVG_BITS + 1)'(ratio_num_w[NUM_BITS-1:RATIO_BITS]);
            qs_g_in    = {ratio_num_w[RATIO_BITS-1:0], (AVG_BITS - RATIO_BITS)'(0)};
            iter_in    = ITER_RATIO;
            rsi_res_in = RSI_FULL;
         end
         OP_DIVR: begin
            rem_g_in = rem_g_step_w;
            qs_g_in  = {qs_g_ff[AVG_BITS-2:0], qbit_g_w};
            iter_in  = iter_ff - ITER_BITS'(1);
         end
         OP_DONE: begin
            rsi_res_in = qs_g_ff[RATIO_BITS-1:0];
         end
         OP_EMIT: begin
            if (!rsp_busy_w) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rsi_res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_WAIT;
         iter_ff       <= '0;
         period_ff     <= PERIOD_RESET;
         last_price_ff <= '0;
         count_ff      <= '0;
         gain_avg_ff   <= '0;
         loss_avg_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         iter_ff       <= iter_in;
         period_ff     <= period_in;
         last_price_ff <= last_price_in;
         count_ff      <= count_in;
         gain_avg_ff   <= gain_avg_in;
         loss_avg_ff   <= loss_avg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      price_ff     <= price_in;
      start_ff     <= start_in;
      gain_x_ff    <= gain_x_in;
      loss_x_ff    <= loss_x_in;
      rem_g_ff     <= rem_g_in;
      qs_g_ff      <= qs_g_in;
      rem_l_ff     <= rem_l_in;
      qs_l_ff      <= qs_l_in;
      sum_ff       <= sum_in;
      rsi_res_ff   <= rsi_res_in;
      rsp_value_ff <= rsp_value_in;
   end

   // checks
   `RSI_ASSERT_IMPL(a_iter_live, (pc_ff == STEP_DIVN) || (pc_ff == STEP_DIVR), iter_ff != '0, "divider step count ran out")
   `RSI_ASSERT_IMPL(a_rem_below_sum, pc_ff == STEP_DIVR, rem_g_ff < sum_ff, "ratio remainder not below divisor")
   `RSI_ASSERT_NEXT(a_accept_to_delta, accept_w, pc_ff == STEP_DELTA, "accepted beat not followed by delta step")
   `RSI_ASSERT_IMPL(a_rsp_range, rsp_valid_ff, rsp_value_ff <= RSI_FULL, "rsi beat above full scale")
   `RSI_ASSERT_IMPL(a_rsp_from_emit, $rose(rsp_valid_ff), $past(pc_ff) == STEP_EMIT, "result raised outside emit step")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: relative strength index testbench
// drives price beats through the req channel, predicts each rsi beat with a
// bit-accurate wilder model held in a small scoreboard class, and checks
// every rsp beat in order; period settings include 0, 1, 2 and 255
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rsi_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int AVG_BITS     = 56;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_TIME  = 100;
   localparam int LONG_HOLD    = 300;

   // wilder rsi predictor and the queue of rsi beats still due
   class rsi_tracker;
      logic [7:0]          period;
      logic [31:0]         last_price;
      logic [7:0]          change_count;
      logic [AVG_BITS-1:0] gain_avg;
      logic [AVG_BITS-1:0] loss_avg;
      logic [14:0]         rsi_due[$];
      int                  errors;
      int                  prices;
      int                  results;

      function new();
         period       = PERIOD_RESET;
         last_price   = '0;
         change_count = '0;
         gain_avg     = '0;
         loss_avg     = '0;
         errors       = 0;
         prices       = 0;
         results      = 0;
      endfunction

      function void set_period(input logic [7:0] n);
         period = n;
      endfunction

      function int outstanding();
         return rsi_due.size();
      endfunction

      // one accepted price beat: update the averages, queue an rsi if due
      function void note_price(input logic [31:0] price, input logic start);
         logic [63:0]  n;
         logic [63:0]  gain;
         logic [63:0]  loss;
         logic [63:0]  total;
         logic [63:0]  tmp;
         logic [127:0] ratio;
         prices++;
         n = (period == 8'd0) ? 64'd1 : {56'd0, period};
         if (start) begin
            last_price   = price;
            change_count = '0;
            gain_avg     = '0;
            loss_avg     = '0;
            return;
         end
         gain = '0;
         loss = '0;
         if (price > last_price)
            gain = ({32'd0, price} - {32'd0, last_price}) << FRAC_BITS;
         else
            loss = ({32'd0, last_price} - {32'd0, price}) << FRAC_BITS;
         last_price = price;
         if ({56'd0, change_count} < n) begin
            // warm-up: sum the changes, seed the averages at the n-th
            gain_avg = gain_avg + gain[AVG_BITS-1:0];
            loss_avg = loss_avg + loss[AVG_BITS-1:0];
            change_count++;
            if ({56'd0, change_count} < n)
               return;
            tmp      = {8'd0, gain_avg} / n;
            gain_avg = tmp[AVG_BITS-1:0];
            tmp      = {8'd0, loss_avg} / n;
            loss_avg = tmp[AVG_BITS-1:0];
         end else begin
            // wilder smoothing
            tmp      = ({8'd0, gain_avg} * (n - 64'd1) + gain) / n;
            gain_avg = tmp[AVG_BITS-1:0];
            tmp      = ({8'd0, loss_avg} * (n - 64'd1) + loss) / n;
            loss_avg = tmp[AVG_BITS-1:0];
         end
         if (loss_avg == '0) begin
            rsi_due.push_back(RSI_FULL);
         end else begin
            total = {8'd0, gain_avg} + {8'd0, loss_avg};
            ratio = ({72'd0, gain_avg} * 128'(RSI_FULL)) / {64'd0, total};
            if (ratio > 128'(RSI_FULL))
               ratio = 128'(RSI_FULL);
            rsi_due.push_back(ratio[14:0]);
         end
      endfunction

      // one accepted rsi beat against the oldest one due
      function void check_rsi(input logic [14:0] value);
         logic [14:0] want;
         results++;
         if (rsi_due.size() == 0) begin
            $error("rsi_value: unexpected beat, actual %0d", value);
            errors++;
            return;
         end
         want = rsi_due.pop_front();
         if (value !== want) begin
            $error("rsi_value mismatch: expected %0d, actual %0d", want, value);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [PERIOD_BITS-1:0] csr_write_data   = '0;

   bit quiet    = 1'b0;
   bit hold_rsp = 1'b0;
   int settings = 0;

   rsi_tracker tracker = new();

   rsi_req_if #(.PRICE_BITS(32)) req_ch ();
   rsi_rsp_if                    rsp_ch ();

   relative_strength_index #(
      .PRICE_BITS          (32),
      .EXTRA_FRACTION_BITS (FRAC_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always #1 clock = ~clock;

   // beat monitor: older rsi first, then the new price
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_rsi(rsp_ch.rsi_value);
         if (req_ch.valid && req_ch.ready)
            tracker.note_price(req_ch.price, req_ch.series_start);
      end
   end

   // watchdog on cycles without any beat
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // result side: random back-pressure bursts and one long hold-off
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            hold_rsp  = 1'b0;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // offer one price beat and wait for it to be taken
   task automatic send_price(input logic [31:0] price, input logic start);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.price        <= price;
      req_ch.series_start <= start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop sending until every rsi is back, then let a warm-up beat finish
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   // period write while the block is idle
   task automatic write_period(input logic [7:0] n);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= n;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_period(n);
      settings++;
   endtask

   // random series: a start, then a walk of prices with some noise
   task automatic random_phase(input logic [7:0] n, input int items, input int run_len,
                               input int noise_pct, input int pause_at, input int hold_at);
      int          sent;
      int          in_run;
      logic [31:0] price;
      logic [31:0] step;
      write_period(n);
      sent   = 0;
      in_run = 0;
      price  = $urandom;
      while (sent < items) begin
         if (sent == pause_at)
            drain();
         if (sent == hold_at)
            hold_rsp = 1'b1;
         if (in_run == 0) begin
            price = $urandom;
            send_price(price, 1'b1);
            in_run = run_len;
         end else if ($urandom_range(0, 99) < noise_pct) begin
            // broken series: restart or jump anywhere
            price = $urandom;
            send_price(price, 1'($urandom_range(0, 1)));
            in_run--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: price = $urandom;
               2: ;
               default: begin
                  step  = $urandom_range(0, 32'd1 << $urandom_range(0, 24));
                  price = $urandom_range(0, 1) ? price + step : price - step;
               end
            endcase
            send_price(price, 1'b0);
            in_run--;
         end
         sent++;
      end
   endtask

   // stimulus
   initial begin : stimulus
      req_ch.valid        = 1'b0;
      req_ch.price        = '0;
      req_ch.series_start = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // first prices after reset, no series start, default period
      send_price(32'h0001_0000, 1'b0);
      send_price(32'h0003_0000, 1'b0);
      send_price(32'h0002_0000, 1'b0);
      // period lowered below the count: smoothing carries on
      write_period(8'd2);
      send_price(32'h0002_0000, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      // period raised above the count: summing resumes
      write_period(8'd6);
      send_price(32'h0000_8000, 1'b0);
      send_price(32'h0000_0000, 1'b0);
      send_price(32'h7FFF_FFFF, 1'b0);
      send_price(32'h7FFF_0000, 1'b0);
      // period one: flat, full loss, zero loss and extremes
      write_period(8'd1);
      send_price(32'hFFFF_FFFF, 1'b1);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'hFFFF_FFFE, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h0000_0000, 1'b1);
      send_price(32'h8000_0000, 1'b0);
      send_price(32'h7FFF_FFFF, 1'b0);
      // period zero acts as one
      write_period(8'd0);
      send_price(32'h1234_5678, 1'b1);
      send_price(32'h1234_5679, 1'b0);
      send_price(32'h1234_0000, 1'b0);

      // random phases
      random_phase(8'd1,   80, 20, 10, -1, -1);
      random_phase(8'd2,   80, 30, 10, 40, -1);
      random_phase(8'd255, 320, 320, 0, -1, -1);
      random_phase(8'd0,   60, 20, 10, -1, -1);
      random_phase(8'($urandom_range(3, 20)), 120, 40, 5, -1, 10);
      quiet = 1'b1;
      random_phase(PERIOD_RESET, 140, 60, 5, -1, -1);

      drain();
      $display("run covered %0d price beats and %0d rsi beats over %0d period settings",
               tracker.prices, tracker.results, settings);
      $display("periods included 0, 1, 2, 6, 14 and 255, with restarts and long stalls");
      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/rsi_pkg.sv
src/rsi_if.sv
src/relative_strength_index.sv
verif/tb_top.sv
